// ----- rtl/core/lta_pkg.sv -----
`default_nettype none

package lta_pkg;

  // Table geometry and timing constants
  localparam int unsigned NumLevels = 8;
  localparam logic [31:0] HoldoffMs = 32'd1000;
  localparam logic [3:0]  MissLimit = 4'd10;
  localparam logic [3:0]  MissRaise = 4'd2;
  localparam logic [63:0] LevelTableRst = 64'd1590915320380916994;

  // Commands
  localparam logic [1:0] CmdReport = 2'd0;
  localparam logic [1:0] CmdReapply = 2'd1;
  localparam logic [1:0] CmdForceUp = 2'd2;

  // Register map, one 64-bit slot per register
  typedef enum logic [2:0] {
    RegHardMax  = 3'd0,
    RegHardMin  = 3'd1,
    RegDynMax   = 3'd2,
    RegDynMin   = 3'd3,
    RegAdaptEn  = 3'd4,
    RegRaiseThr = 3'd5,
    RegLowerThr = 3'd6,
    RegLevelTbl = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  hard_max_dbm;
    logic [7:0]  hard_min_dbm;
    logic [7:0]  dyn_max_dbm;
    logic [7:0]  dyn_min_dbm;
    logic        adapt_enable;
    logic [23:0] raise_thresholds;
    logic [23:0] lower_thresholds;
    logic [63:0] level_table;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        command;
    logic              packet_received;
    logic signed [7:0] rssi_dbm;
    logic signed [7:0] snr_db;
    logic [7:0]        link_quality;
    logic [31:0]       time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] power_dbm;
    logic       power_changed;
    logic [3:0] missed_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
  } limits_t;

  function automatic logic [7:0] level_at(input logic [63:0] tbl, input logic [2:0] idx);
    return tbl[{idx, 3'b000} +: 8];
  endfunction

  // Snap the hard limits onto table levels
  function automatic limits_t snap_limits(input logic [63:0] tbl, input logic [7:0] hmax,
                                          input logic [7:0] hmin);
    limits_t    lim;
    logic       mx_done;
    logic       mn_done;
    logic [7:0] lv;
    lim.hi = level_at(tbl, 3'd0);
    lim.lo = level_at(tbl, 3'(NumLevels - 1));
    mx_done = 1'b0;
    mn_done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      lv = level_at(tbl, 3'(i));
      if (i < NumLevels) begin
        if (!mx_done) begin
          if (lv <= hmax) lim.hi = lv;
          else mx_done = 1'b1;
        end
        if (!mn_done && lv >= hmin) begin
          lim.lo = lv;
          mn_done = 1'b1;
        end
      end
    end
    if (lim.hi < lim.lo) lim.lo = lim.hi;
    return lim;
  endfunction

  // Last in-limit level at or below the request; floor when none
  function automatic logic [7:0] select_level(input logic [63:0] tbl, input limits_t lim,
                                              input logic [7:0] req);
    logic [7:0] sel;
    logic       done;
    logic [7:0] lv;
    sel = lim.lo;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      lv = level_at(tbl, 3'(i));
      if (i < NumLevels && !done && lv >= lim.lo && lv <= lim.hi) begin
        if (lv <= req) sel = lv;
        else done = 1'b1;
      end
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lta_stream_if.sv -----
`default_nettype none

interface lta_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lta_cfg_regs.sv -----
`default_nettype none

module lta_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output lta_pkg::cfg_t     cfg_o
);
  import lta_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegHardMax:  cfg_d.hard_max_dbm     = pwdata[7:0];
        RegHardMin:  cfg_d.hard_min_dbm     = pwdata[7:0];
        RegDynMax:   cfg_d.dyn_max_dbm      = pwdata[7:0];
        RegDynMin:   cfg_d.dyn_min_dbm      = pwdata[7:0];
        RegAdaptEn:  cfg_d.adapt_enable     = pwdata[0];
        RegRaiseThr: cfg_d.raise_thresholds = pwdata[23:0];
        RegLowerThr: cfg_d.lower_thresholds = pwdata[23:0];
        RegLevelTbl: cfg_d.level_table      = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegHardMax:  prdata = {56'd0, cfg_q.hard_max_dbm};
      RegHardMin:  prdata = {56'd0, cfg_q.hard_min_dbm};
      RegDynMax:   prdata = {56'd0, cfg_q.dyn_max_dbm};
      RegDynMin:   prdata = {56'd0, cfg_q.dyn_min_dbm};
      RegAdaptEn:  prdata = {63'd0, cfg_q.adapt_enable};
      RegRaiseThr: prdata = {40'd0, cfg_q.raise_thresholds};
      RegLowerThr: prdata = {40'd0, cfg_q.lower_thresholds};
      RegLevelTbl: prdata = cfg_q.level_table;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hard_max_dbm     <= 8'd255;
      cfg_q.hard_min_dbm     <= 8'd0;
      cfg_q.dyn_max_dbm      <= 8'd255;
      cfg_q.dyn_min_dbm      <= 8'd0;
      cfg_q.adapt_enable     <= 1'b1;
      cfg_q.raise_thresholds <= 24'd0;
      cfg_q.lower_thresholds <= 24'd0;
      cfg_q.level_table      <= LevelTableRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lta_power_ctrl.sv -----
`default_nettype none

module lta_power_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lta_pkg::cfg_t     cfg_i,
  input  wire logic              fire_i,
  input  wire lta_pkg::in_item_t item_i,
  output lta_pkg::out_item_t     result_o
);
  import lta_pkg::*;

  logic [7:0]  power_q, power_d;
  logic [3:0]  miss_q, miss_d;
  logic [31:0] drop_time_q, drop_time_d;

  limits_t     lim;
  logic [63:0] tbl;

  assign tbl = cfg_i.level_table;
  assign lim = snap_limits(tbl, cfg_i.hard_max_dbm, cfg_i.hard_min_dbm);

  always_comb begin
    logic              up_found;
    logic [7:0]        up_lv;
    logic              dn_found;
    logic [7:0]        dn_lv;
    logic [7:0]        lv;
    logic [7:0]        up_auto;
    logic [7:0]        up_force;
    logic              up_ok;
    logic              dn_ok;
    logic [7:0]        reap;
    logic [3:0]        miss_nx;
    logic              miss_raise;
    logic              inc;
    logic              dec;
    logic [31:0]       elapsed;
    logic signed [7:0] r_rssi, r_snr, l_rssi, l_snr;

    // Next level above and below the current power
    up_found = 1'b0;
    up_lv    = '0;
    dn_found = 1'b0;
    dn_lv    = '0;
    for (int i = 0; i < 8; i++) begin
      lv = level_at(tbl, 3'(i));
      if (i < NumLevels && !up_found && lv > power_q) begin
        up_found = 1'b1;
        up_lv    = lv;
      end
    end
    for (int i = 7; i >= 0; i--) begin
      lv = level_at(tbl, 3'(i));
      if (i < NumLevels && !dn_found && lv < power_q) begin
        dn_found = 1'b1;
        dn_lv    = lv;
      end
    end

    up_ok    = up_found && up_lv >= lim.lo && up_lv <= lim.hi;
    dn_ok    = dn_found && dn_lv >= lim.lo && dn_lv <= lim.hi;
    up_force = up_ok ? select_level(tbl, lim, up_lv) : power_q;
    up_auto  = (up_ok && up_lv <= cfg_i.dyn_max_dbm) ? up_force : power_q;

    // Re-apply limits: clamp into hard limits, then into the dynamic window; pin to dyn_max when adaptation is off
    reap = select_level(tbl, lim, power_q);
    if (!cfg_i.adapt_enable) reap = select_level(tbl, lim, cfg_i.dyn_max_dbm);
    else if (reap < cfg_i.dyn_min_dbm) reap = select_level(tbl, lim, cfg_i.dyn_min_dbm);
    else if (reap > cfg_i.dyn_max_dbm) reap = select_level(tbl, lim, cfg_i.dyn_max_dbm);

    // Link report decision
    miss_nx = (!item_i.packet_received && miss_q < MissLimit) ? miss_q + 4'd1 : 4'd0;
    miss_raise = !item_i.packet_received && miss_nx >= MissRaise;
    r_rssi = $signed(cfg_i.raise_thresholds[7:0]);
    r_snr  = $signed(cfg_i.raise_thresholds[15:8]);
    l_rssi = $signed(cfg_i.lower_thresholds[7:0]);
    l_snr  = $signed(cfg_i.lower_thresholds[15:8]);
    inc = item_i.rssi_dbm < r_rssi || item_i.snr_db < r_snr
       || item_i.link_quality < cfg_i.raise_thresholds[23:16] || miss_raise
       || power_q < cfg_i.dyn_min_dbm;
    dec = item_i.rssi_dbm > l_rssi && item_i.snr_db > l_snr
       && item_i.link_quality > cfg_i.lower_thresholds[23:16] && item_i.packet_received;
    elapsed = item_i.time_ms - drop_time_q;

    power_d     = power_q;
    miss_d      = miss_q;
    drop_time_d = drop_time_q;
    case (item_i.command)
      CmdReport: begin
        if (cfg_i.adapt_enable) begin
          miss_d = miss_nx;
          if (inc && power_q < cfg_i.dyn_max_dbm) begin
            power_d = up_auto;
          end else if (dec && power_q > cfg_i.dyn_min_dbm && elapsed > HoldoffMs) begin
            if (dn_ok) begin
              power_d     = select_level(tbl, lim, dn_lv);
              drop_time_d = item_i.time_ms;
            end
          end
        end
      end
      CmdReapply: power_d = reap;
      CmdForceUp: power_d = up_force;
      default: ;
    endcase

    result_o.power_dbm     = power_d;
    result_o.power_changed = power_d != power_q;
    result_o.missed_count  = miss_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q     <= LevelTableRst[7:0];
      miss_q      <= '0;
      drop_time_q <= '0;
    end else if (fire_i) begin
      power_q     <= power_d;
      miss_q      <= miss_d;
      drop_time_q <= drop_time_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/link_tx_power_adapter.sv -----
// Transmit power adapter for a radio link.
// Input channel in_i carries one word per event: a link report, a request to
// re-apply the power limits, or a forced step up. Output channel out_o returns
// one word per input word: the selected power level, a changed flag and the
// consecutive missed-packet count. Both channels use valid/ready handshakes.
// A word accepted on in_i is held in the input register, evaluated there
// and loaded into the result register that drives out_o once that is free.
// Throughput: one word per cycle while out_o does not stall; the power
// decision is a single pass over the eight-entry level table between the
// input and result registers.
// The APB port writes the limits, thresholds and level table; writes take
// effect on the next word. Registers sit at byte address 8*index.
// Reset: power returns to the lowest entry of the default table, the missed
// counter and drop timestamp clear, registers take their default values and
// both pipeline stages empty.
// Back-pressure: when out_o stalls the result holds, the input stage holds
// its word and in_i.ready drops only once both stages are full.
`default_nettype none

module link_tx_power_adapter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lta_stream_if.sink       in_i,
  lta_stream_if.source     out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import lta_pkg::*;

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t res_d;
  out_item_t res_q;
  logic      res_valid_q;
  logic      advance;
  logic      fire;
  logic      in_take;

  lta_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the input stage whenever the result register is free or draining
  assign advance     = !res_valid_q || out_o.ready;
  assign fire        = item_valid_q && advance;
  assign in_i.ready  = !item_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;

  lta_power_ctrl u_power_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign out_o.valid   = res_valid_q;
  assign out_o.payload = res_q;

  // Control: stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_take) item_valid_q <= 1'b1;
      else if (fire) item_valid_q <= 1'b0;
      if (fire) res_valid_q <= 1'b1;
      else if (out_o.ready) res_valid_q <= 1'b0;
    end
  end

  // Payload: capture incoming word, load result
  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= in_i.payload;
    if (fire) res_q <= res_d;
  end

endmodule

`default_nettype wire

// ----- tb/link_tx_power_adapter_test.sv -----
`default_nettype none

module link_tx_power_adapter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lta_pkg::*;

  // Command code 3 is not decoded by the block; the result just echoes state
  localparam logic [1:0] CmdUnused = 2'd3;

  // Cycles with no word moving on either channel before the run is abandoned.
  // The busiest correct gap is a config phase (eight APB writes) plus drain.
  localparam int StallLimit = 2000;

  localparam int ItemsPerPhase = 220;
  localparam int NumPhases = 9;

  logic clk_i;
  logic rst_ni;

  // APB side of the block
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  lta_stream_if #(.payload_t(in_item_t))  in_if ();
  lta_stream_if #(.payload_t(out_item_t)) out_if ();

  link_tx_power_adapter u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Words waiting to be offered on in_i, and results owed on out_o
  in_item_t  reports_to_send[$];
  out_item_t power_words_due[$];

  // Shadow of the register file and of the adapter state
  cfg_t        model_cfg;
  cfg_t        plan;
  logic [7:0]  tx_power;
  logic [3:0]  miss_cnt;
  logic [31:0] drop_stamp;
  logic [7:0]  floor_lvl;
  logic [7:0]  ceil_lvl;

  // Stimulus state: running millisecond clock and length of a forced miss run
  logic [31:0] clock_ms;
  int          miss_run;
  bit          steady;

  int        mismatches;
  int        idle_cycles;
  out_item_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    $display("%0t ns: power word mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Power adapter model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] table_entry(input int i);
    return model_cfg.level_table[8*i +: 8];
  endfunction

  // Hard ceiling snaps down along the table until the first larger entry;
  // hard floor snaps up to the first entry at or above it. A crossed pair
  // pulls the floor down onto the ceiling.
  function automatic void snap_model_limits();
    ceil_lvl = table_entry(0);
    floor_lvl = table_entry(NumLevels - 1);
    for (int i = 0; i < NumLevels; i++) begin
      if (table_entry(i) > model_cfg.hard_max_dbm) break;
      ceil_lvl = table_entry(i);
    end
    for (int i = 0; i < NumLevels; i++) begin
      if (table_entry(i) >= model_cfg.hard_min_dbm) begin
        floor_lvl = table_entry(i);
        break;
      end
    end
    if (ceil_lvl < floor_lvl) floor_lvl = ceil_lvl;
  endfunction

  // Last in-limit entry not above the request, scanning upward and stopping
  // at the first in-limit entry above it; the floor if nothing qualifies
  function automatic void settle_power(input logic [7:0] req);
    logic [7:0] lv;
    logic [7:0] pick;
    pick = floor_lvl;
    for (int i = 0; i < NumLevels; i++) begin
      lv = table_entry(i);
      if (lv >= floor_lvl && lv <= ceil_lvl) begin
        if (lv > req) break;
        pick = lv;
      end
    end
    tx_power = pick;
  endfunction

  // Only the first entry above the current power is a candidate
  function automatic void step_power_up(input bit forced);
    logic [7:0] lv;
    for (int i = 0; i < NumLevels; i++) begin
      lv = table_entry(i);
      if (lv > tx_power) begin
        if (lv >= floor_lvl && lv <= ceil_lvl && (forced || lv <= model_cfg.dyn_max_dbm))
          settle_power(lv);
        return;
      end
    end
  endfunction

  function automatic void step_power_down(input logic [31:0] now);
    logic [7:0] lv;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      lv = table_entry(i);
      if (lv < tx_power) begin
        if (lv >= floor_lvl && lv <= ceil_lvl) begin
          drop_stamp = now;
          settle_power(lv);
        end
        return;
      end
    end
  endfunction

  function automatic void reapply_limits();
    settle_power(tx_power);
    if (!model_cfg.adapt_enable) settle_power(model_cfg.dyn_max_dbm);
    else if (tx_power < model_cfg.dyn_min_dbm) settle_power(model_cfg.dyn_min_dbm);
    else if (tx_power > model_cfg.dyn_max_dbm) settle_power(model_cfg.dyn_max_dbm);
  endfunction

  function automatic void handle_link_report(input in_item_t w);
    logic signed [7:0] rssi;
    logic signed [7:0] snr;
    logic              want_up;
    logic              want_down;
    logic [31:0]       gap;
    if (!model_cfg.adapt_enable) return;
    if (!w.packet_received && miss_cnt < MissLimit) miss_cnt = miss_cnt + 4'd1;
    else miss_cnt = 4'd0;
    rssi = w.rssi_dbm;
    snr = w.snr_db;
    want_up = rssi < $signed(model_cfg.raise_thresholds[7:0])
           || snr < $signed(model_cfg.raise_thresholds[15:8])
           || w.link_quality < model_cfg.raise_thresholds[23:16]
           || (!w.packet_received && miss_cnt >= MissRaise)
           || tx_power < model_cfg.dyn_min_dbm;
    want_down = rssi > $signed(model_cfg.lower_thresholds[7:0])
             && snr > $signed(model_cfg.lower_thresholds[15:8])
             && w.link_quality > model_cfg.lower_thresholds[23:16]
             && w.packet_received;
    // hold-off is measured modulo 2^32
    gap = w.time_ms - drop_stamp;
    if (want_up && tx_power < model_cfg.dyn_max_dbm) step_power_up(1'b0);
    else if (want_down && tx_power > model_cfg.dyn_min_dbm && gap > HoldoffMs)
      step_power_down(w.time_ms);
  endfunction

  function automatic out_item_t advance_power(input in_item_t w);
    out_item_t  r;
    logic [7:0] prior;
    prior = tx_power;
    snap_model_limits();
    case (w.command)
      CmdReport:  handle_link_report(w);
      CmdReapply: reapply_limits();
      CmdForceUp: step_power_up(1'b1);
      default: ;
    endcase
    r.power_dbm = tx_power;
    r.power_changed = (tx_power != prior);
    r.missed_count = miss_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued words on in_i, idling at random unless steady is set.
  // The expected result is worked out at the edge that accepts the word.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
    end else begin
      if (in_if.valid && in_if.ready) power_words_due.push_back(advance_power(in_if.payload));
      // hold the word until it is taken, then advance or drop valid
      if (!in_if.valid || in_if.ready) begin
        if (reports_to_send.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
          in_if.valid <= 1'b1;
          in_if.payload <= reports_to_send.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall out_o at random, compare each result with the oldest owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (power_words_due.size() == 0) begin
          report($sformatf("result word %h arrived with none expected", out_if.payload));
        end else begin
          want = power_words_due.pop_front();
          if (out_if.payload.power_dbm !== want.power_dbm)
            report($sformatf("power_dbm got %0d want %0d",
                             out_if.payload.power_dbm, want.power_dbm));
          if (out_if.payload.power_changed !== want.power_changed)
            report($sformatf("power_changed got %b want %b",
                             out_if.payload.power_changed, want.power_changed));
          if (out_if.payload.missed_count !== want.missed_count)
            report($sformatf("missed_count got %0d want %0d",
                             out_if.payload.missed_count, want.missed_count));
        end
      end
      out_if.ready <= steady || $urandom_range(99) >= 38;
    end
  end

  // Watchdog: abandon the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge where the access phase completes
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegHardMax:  model_cfg.hard_max_dbm = value[7:0];
      RegHardMin:  model_cfg.hard_min_dbm = value[7:0];
      RegDynMax:   model_cfg.dyn_max_dbm = value[7:0];
      RegDynMin:   model_cfg.dyn_min_dbm = value[7:0];
      RegAdaptEn:  model_cfg.adapt_enable = value[0];
      RegRaiseThr: model_cfg.raise_thresholds = value[23:0];
      RegLowerThr: model_cfg.lower_thresholds = value[23:0];
      RegLevelTbl: model_cfg.level_table = value;
      default: ;
    endcase
  endtask

  // Wait until every queued word went in and every result came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (reports_to_send.size() != 0 || in_if.valid || power_words_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic in_item_t report_word(input logic [1:0] cmd, input bit rx,
                                           input logic [7:0] rssi, input logic [7:0] snr,
                                           input logic [7:0] lq, input logic [31:0] t);
    in_item_t w;
    w.command = cmd;
    w.packet_received = rx;
    w.rssi_dbm = rssi;
    w.snr_db = snr;
    w.link_quality = lq;
    w.time_ms = t;
    return w;
  endfunction

  // Non-decreasing table with occasional repeated entries
  function automatic logic [63:0] rising_table();
    logic [63:0] t;
    int          lv;
    lv = $urandom_range(40);
    for (int i = 0; i < 8; i++) begin
      t[8*i +: 8] = 8'(lv);
      lv = lv + $urandom_range(30);
      if (lv > 255) lv = 255;
    end
    return t;
  endfunction

  // Raise thresholds well under the lowering ones, so both directions occur
  task automatic plan_moderate_thresholds();
    int r_rssi;
    int r_snr;
    int r_lq;
    r_rssi = -int'($urandom_range(100, 20));
    r_snr = $urandom_range(10);
    r_lq = $urandom_range(120, 30);
    plan.raise_thresholds = {8'(r_lq), 8'(r_snr), 8'(r_rssi)};
    plan.lower_thresholds = {8'(r_lq + int'($urandom_range(100, 10))),
                             8'(r_snr + int'($urandom_range(30, 5))),
                             8'(r_rssi + int'($urandom_range(40, 10)))};
  endtask

  // Mostly link reports on an advancing clock, with runs of misses, reports
  // aimed just above the lowering thresholds or around the raise thresholds,
  // and some fully random words
  task automatic queue_random_reports(input int count);
    in_item_t    w;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 80) w.command = CmdReport;
      else if (pick < 88) w.command = CmdReapply;
      else if (pick < 95) w.command = CmdForceUp;
      else w.command = CmdUnused;
      if ($urandom_range(99) < 4) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(1500);
      w.time_ms = clock_ms;
      if (miss_run == 0 && $urandom_range(99) < 8) miss_run = $urandom_range(13, 1);
      if (miss_run != 0) begin
        w.packet_received = 1'b0;
        miss_run--;
      end else begin
        w.packet_received = ($urandom_range(99) < 85);
      end
      case ($urandom_range(2))
        0: begin
          w.rssi_dbm = model_cfg.lower_thresholds[7:0] + 8'($urandom_range(20, 1));
          w.snr_db = model_cfg.lower_thresholds[15:8] + 8'($urandom_range(20, 1));
          w.link_quality = model_cfg.lower_thresholds[23:16] + 8'($urandom_range(20, 1));
        end
        1: begin
          w.rssi_dbm = model_cfg.raise_thresholds[7:0] + 8'($urandom_range(8)) - 8'd4;
          w.snr_db = model_cfg.raise_thresholds[15:8] + 8'($urandom_range(8)) - 8'd4;
          w.link_quality = model_cfg.raise_thresholds[23:16] + 8'($urandom_range(8)) - 8'd4;
        end
        default: begin
          w.rssi_dbm = 8'($urandom());
          w.snr_db = 8'($urandom());
          w.link_quality = 8'($urandom());
        end
      endcase
      reports_to_send.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    clock_ms = '0;
    miss_run = 0;
    mismatches = 0;
    idle_cycles = 0;

    // Register defaults and adapter state after reset
    model_cfg.hard_max_dbm = 8'd255;
    model_cfg.hard_min_dbm = 8'd0;
    model_cfg.dyn_max_dbm = 8'd255;
    model_cfg.dyn_min_dbm = 8'd0;
    model_cfg.adapt_enable = 1'b1;
    model_cfg.raise_thresholds = '0;
    model_cfg.lower_thresholds = '0;
    model_cfg.level_table = LevelTableRst;
    tx_power = LevelTableRst[7:0];
    miss_cnt = '0;
    drop_stamp = '0;

    // Directed words against the default registers (thresholds all zero)
    // strong report at time zero: hold-off not yet expired
    reports_to_send.push_back(report_word(CmdReport, 1'b1, 8'h7F, 8'h7F, 8'hFF, 32'd0));
    // forced steps up, two levels
    reports_to_send.push_back(report_word(CmdForceUp, 1'b0, 8'h00, 8'h00, 8'h00, 32'd0));
    reports_to_send.push_back(report_word(CmdForceUp, 1'b0, 8'h00, 8'h00, 8'h00, 32'd0));
    // strong report past the hold-off: drop one level
    reports_to_send.push_back(report_word(CmdReport, 1'b1, 8'h7F, 8'h7F, 8'hFF, 32'd1001));
    // exactly the hold-off since the drop: no drop
    reports_to_send.push_back(report_word(CmdReport, 1'b1, 8'h01, 8'h01, 8'h01, 32'd2001));
    // one past it: drop
    reports_to_send.push_back(report_word(CmdReport, 1'b1, 8'h01, 8'h01, 8'h01, 32'd2002));
    // twelve misses in a row: counter climbs to ten, wraps to zero, restarts
    for (int k = 0; k < 12; k++)
      reports_to_send.push_back(report_word(CmdReport, 1'b0, 8'h00, 8'h00, 8'h00,
                                            32'd3000 + 32'(k)));
    // weakest possible report: raise
    reports_to_send.push_back(report_word(CmdReport, 1'b1, 8'h80, 8'h80, 8'h00, 32'd4000));
    reports_to_send.push_back(report_word(CmdReapply, 1'b1, 8'h55, 8'hAA, 8'h5A, 32'd4100));
    // undecoded command: state must come back unchanged
    reports_to_send.push_back(report_word(CmdUnused, 1'b1, 8'hFF, 8'h80, 8'hAA,
                                          32'h5555_AAAA));
    // hold-off across the 32-bit wrap of the timestamp
    reports_to_send.push_back(report_word(CmdReport, 1'b1, 8'h7F, 8'h7F, 8'hFF,
                                          32'hFFFF_FFFF));
    reports_to_send.push_back(report_word(CmdReport, 1'b1, 8'h7F, 8'h7F, 8'hFF,
                                          32'h0000_0100));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    for (int phase = 1; phase <= NumPhases; phase++) begin
      plan = model_cfg;
      plan.hard_max_dbm = 8'd255;
      plan.hard_min_dbm = 8'd0;
      plan.dyn_max_dbm = 8'd255;
      plan.dyn_min_dbm = 8'd0;
      plan.adapt_enable = 1'b1;
      plan_moderate_thresholds();
      case (phase)
        1: plan.level_table = rising_table();
        2: begin
          // random limits, crossing hard limits possible
          plan.level_table = rising_table();
          plan.hard_max_dbm = 8'($urandom_range(255));
          plan.hard_min_dbm = 8'($urandom_range(255));
          plan.dyn_max_dbm = 8'($urandom_range(255));
          plan.dyn_min_dbm = 8'($urandom_range(255));
        end
        3: begin
          // unordered table, no idling on either channel
          plan.level_table = {32'($urandom()), 32'($urandom())};
          plan.dyn_max_dbm = 8'($urandom_range(255));
          plan.dyn_min_dbm = 8'($urandom_range(128));
        end
        4: begin
          // hard limits fully crossed; almost every report looks weak
          plan.level_table = LevelTableRst;
          plan.hard_max_dbm = 8'd0;
          plan.hard_min_dbm = 8'd255;
          plan.raise_thresholds = 24'hFF_FFFF;
          plan.lower_thresholds = 24'h00_0000;
        end
        5: begin
          // adaptation off: reports inert, re-apply pins dyn_max
          plan.level_table = rising_table();
          plan.adapt_enable = 1'b0;
          plan.dyn_max_dbm = 8'($urandom_range(255));
          plan.dyn_min_dbm = 8'($urandom_range(255));
        end
        6: begin
          // dynamic window inverted, extreme thresholds the other way
          plan.level_table = rising_table();
          plan.dyn_max_dbm = 8'd0;
          plan.dyn_min_dbm = 8'd255;
          plan.raise_thresholds = 24'h00_0000;
          plan.lower_thresholds = 24'hFF_FFFF;
        end
        7: begin
          plan.level_table = {32'($urandom()), 32'($urandom())};
          plan.hard_max_dbm = 8'($urandom_range(255));
          plan.hard_min_dbm = 8'($urandom_range(255));
          plan.raise_thresholds = 24'($urandom());
          plan.lower_thresholds = 24'($urandom());
        end
        8: begin
          // every level at full scale, ceiling just under it
          plan.level_table = 64'hFFFF_FFFF_FFFF_FFFF;
          plan.hard_max_dbm = 8'd254;
        end
        default: begin
          plan.level_table = rising_table();
          plan.hard_max_dbm = 8'($urandom_range(255, 100));
          plan.hard_min_dbm = 8'($urandom_range(100));
          plan.dyn_max_dbm = 8'($urandom_range(255));
          plan.dyn_min_dbm = 8'($urandom_range(255));
        end
      endcase
      steady = (phase == 3);
      write_reg(RegHardMax, 64'(plan.hard_max_dbm));
      write_reg(RegHardMin, 64'(plan.hard_min_dbm));
      write_reg(RegDynMax, 64'(plan.dyn_max_dbm));
      write_reg(RegDynMin, 64'(plan.dyn_min_dbm));
      write_reg(RegAdaptEn, 64'(plan.adapt_enable));
      write_reg(RegRaiseThr, 64'(plan.raise_thresholds));
      write_reg(RegLowerThr, 64'(plan.lower_thresholds));
      write_reg(RegLevelTbl, plan.level_table);
      // queue away from the clock edge the driver pops on
      @(negedge clk_i);
      queue_random_reports(ItemsPerPhase);
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (power_words_due.size() != 0)
      report($sformatf("%0d result words never arrived", power_words_due.size()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
